// ===== rtl/hsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV colour classifier package
// Widths, register indexes, class codes and the word that travels along the
// division chain.
// ----------------------------------------------------------------------------
package hsvc_pkg;

    localparam int ChanW  = 8;
    localparam int HueW   = 9;
    localparam int ClassW = 2;
    localparam int IndexW = 3;
    localparam int DataW  = 9;

    // Division chain: one quotient bit per cell, both quotients stay below 512.
    localparam int QuotW = 9;
    localparam int DivW  = 18;
    localparam int DsrW  = ChanW + 1;
    localparam int NumW  = 17;

    localparam int HueBlueBase  = 240;
    localparam int HueGreenBase = 120;
    localparam int HueSector    = 60;
    localparam int HueFull      = 360;
    localparam int SatScale2    = 2 * 255;

    localparam logic [IndexW-1:0] REG_BLACK_VALUE_LIMIT = 3'd0;
    localparam logic [IndexW-1:0] REG_RED_LOW_HUE_MAX   = 3'd1;
    localparam logic [IndexW-1:0] REG_RED_HIGH_HUE_MIN  = 3'd2;
    localparam logic [IndexW-1:0] REG_BLUE_HUE_MIN      = 3'd3;
    localparam logic [IndexW-1:0] REG_BLUE_HUE_MAX      = 3'd4;

    localparam logic [ChanW-1:0] BLACK_VALUE_LIMIT_RST = 8'd50;
    localparam logic [HueW-1:0]  RED_LOW_HUE_MAX_RST   = 9'd15;
    localparam logic [HueW-1:0]  RED_HIGH_HUE_MIN_RST  = 9'd340;
    localparam logic [HueW-1:0]  BLUE_HUE_MIN_RST      = 9'd200;
    localparam logic [HueW-1:0]  BLUE_HUE_MAX_RST      = 9'd260;

    localparam logic [ClassW-1:0] CLASS_BLACK = 2'd0;
    localparam logic [ClassW-1:0] CLASS_RED   = 2'd1;
    localparam logic [ClassW-1:0] CLASS_BLUE  = 2'd2;
    localparam logic [ClassW-1:0] CLASS_NONE  = 2'd3;

    typedef struct packed {
        logic [ChanW-1:0] black_value_limit;
        logic [HueW-1:0]  red_low_hue_max;
        logic [HueW-1:0]  red_high_hue_min;
        logic [HueW-1:0]  blue_hue_min;
        logic [HueW-1:0]  blue_hue_max;
    } thresholds_t;

    typedef struct packed {
        logic [DivW-1:0]  sat_rem;
        logic [DsrW-1:0]  sat_dsr;
        logic [QuotW-1:0] sat_quo;
        logic [DivW-1:0]  hue_rem;
        logic [DsrW-1:0]  hue_dsr;
        logic [QuotW-1:0] hue_quo;
        logic [ChanW-1:0] value;
        logic             zero;
    } div_word_t;

endpackage

// ===== rtl/hsvc_if.sv =====
// ----------------------------------------------------------------------------
// HSV colour classifier channels
// Pixel input, result output and register write channels.
// ----------------------------------------------------------------------------
interface hsvc_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [hsvc_pkg::ChanW-1:0] blue_level;
    logic [hsvc_pkg::ChanW-1:0] green_level;
    logic [hsvc_pkg::ChanW-1:0] red_level;

    modport source (output valid, output blue_level, output green_level,
                    output red_level, input ready);
    modport sink (input valid, input blue_level, input green_level,
                  input red_level, output ready);
endinterface

interface hsvc_result_if;
    logic                        valid;
    logic                        ready;
    logic [hsvc_pkg::ClassW-1:0] colour_class;
    logic [hsvc_pkg::HueW-1:0]   hue_degrees;
    logic [hsvc_pkg::ChanW-1:0]  saturation_level;
    logic [hsvc_pkg::ChanW-1:0]  value_level;

    modport source (output valid, output colour_class, output hue_degrees,
                    output saturation_level, output value_level, input ready);
    modport sink (input valid, input colour_class, input hue_degrees,
                  input saturation_level, input value_level, output ready);
endinterface

interface hsvc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [hsvc_pkg::IndexW-1:0] index;
    logic [hsvc_pkg::DataW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/hsvc_prep_cell.sv =====
// ----------------------------------------------------------------------------
// HSV colour classifier front cell
// Finds value, chroma and the hue sector and forms both rounded dividends.
// ----------------------------------------------------------------------------
module hsvc_prep_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hsvc_pkg::ChanW-1:0] blue_level,
    input  logic [hsvc_pkg::ChanW-1:0] green_level,
    input  logic [hsvc_pkg::ChanW-1:0] red_level,
    output logic                       out_valid,
    input  logic                       out_ready,
    output hsvc_pkg::div_word_t        out_word
);

    logic                       valid_reg;
    hsvc_pkg::div_word_t        word_reg;
    hsvc_pkg::div_word_t        word_next;
    logic [hsvc_pkg::ChanW-1:0] mx;
    logic [hsvc_pkg::ChanW-1:0] mn;
    logic [hsvc_pkg::ChanW-1:0] d;
    logic [hsvc_pkg::NumW-1:0]  num;
    logic [hsvc_pkg::NumW-1:0]  d_w;

    function automatic logic [hsvc_pkg::NumW-1:0] sector(
        input logic [hsvc_pkg::ChanW-1:0] a,
        input logic [hsvc_pkg::ChanW-1:0] b
    );
        logic [hsvc_pkg::ChanW-1:0] diff;
        diff = (a >= b) ? (a - b) : (b - a);
        return hsvc_pkg::NumW'(hsvc_pkg::HueSector) * hsvc_pkg::NumW'(diff);
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        mx = blue_level;
        if (green_level > mx)
        begin
            mx = green_level;
        end
        if (red_level > mx)
        begin
            mx = red_level;
        end
        mn = blue_level;
        if (green_level < mn)
        begin
            mn = green_level;
        end
        if (red_level < mn)
        begin
            mn = red_level;
        end
        d   = mx - mn;
        d_w = hsvc_pkg::NumW'(d);

        if (blue_level >= green_level && blue_level >= red_level)
        begin
            if (red_level >= green_level)
            begin
                num = hsvc_pkg::NumW'(hsvc_pkg::HueBlueBase) * d_w
                    + sector(red_level, green_level);
            end
            else
            begin
                num = hsvc_pkg::NumW'(hsvc_pkg::HueBlueBase) * d_w
                    - sector(red_level, green_level);
            end
        end
        else if (green_level >= red_level)
        begin
            if (blue_level >= red_level)
            begin
                num = hsvc_pkg::NumW'(hsvc_pkg::HueGreenBase) * d_w
                    + sector(blue_level, red_level);
            end
            else
            begin
                num = hsvc_pkg::NumW'(hsvc_pkg::HueGreenBase) * d_w
                    - sector(blue_level, red_level);
            end
        end
        else
        begin
            if (green_level >= blue_level)
            begin
                num = sector(green_level, blue_level);
            end
            else
            begin
                num = hsvc_pkg::NumW'(hsvc_pkg::HueFull) * d_w
                    - sector(green_level, blue_level);
            end
        end

        word_next.sat_rem = hsvc_pkg::DivW'(hsvc_pkg::SatScale2) * hsvc_pkg::DivW'(d)
                          + hsvc_pkg::DivW'(mx);
        word_next.sat_dsr = {mx, 1'b0};
        word_next.sat_quo = '0;
        word_next.hue_rem = {num, 1'b0} + hsvc_pkg::DivW'(d);
        word_next.hue_dsr = {d, 1'b0};
        word_next.hue_quo = '0;
        word_next.value   = mx;
        word_next.zero    = (d == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/hsvc_div_cell.sv =====
// ----------------------------------------------------------------------------
// HSV colour classifier division cell
// Settles one quotient bit of both the saturation and the hue division.
// ----------------------------------------------------------------------------
module hsvc_div_cell #(
    parameter int BitIndex = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hsvc_pkg::div_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output hsvc_pkg::div_word_t out_word
);

    logic                      valid_reg;
    hsvc_pkg::div_word_t       word_reg;
    hsvc_pkg::div_word_t       word_next;
    logic [hsvc_pkg::DivW-1:0] sat_cmp;
    logic [hsvc_pkg::DivW-1:0] hue_cmp;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sat_cmp   = hsvc_pkg::DivW'(in_word.sat_dsr) << BitIndex;
        hue_cmp   = hsvc_pkg::DivW'(in_word.hue_dsr) << BitIndex;
        word_next = in_word;
        if (in_word.sat_rem >= sat_cmp)
        begin
            word_next.sat_rem           = in_word.sat_rem - sat_cmp;
            word_next.sat_quo[BitIndex] = 1'b1;
        end
        if (in_word.hue_rem >= hue_cmp)
        begin
            word_next.hue_rem           = in_word.hue_rem - hue_cmp;
            word_next.hue_quo[BitIndex] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/hsvc_class_cell.sv =====
// ----------------------------------------------------------------------------
// HSV colour classifier output cell
// Wraps the hue, applies the grey case and classifies against the thresholds.
// ----------------------------------------------------------------------------
module hsvc_class_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  hsvc_pkg::div_word_t         in_word,
    input  hsvc_pkg::thresholds_t       thresholds,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hsvc_pkg::ClassW-1:0] colour_class,
    output logic [hsvc_pkg::HueW-1:0]   hue_degrees,
    output logic [hsvc_pkg::ChanW-1:0]  saturation_level,
    output logic [hsvc_pkg::ChanW-1:0]  value_level
);

    logic                        valid_reg;
    logic [hsvc_pkg::ClassW-1:0] class_reg;
    logic [hsvc_pkg::ClassW-1:0] class_next;
    logic [hsvc_pkg::HueW-1:0]   hue_reg;
    logic [hsvc_pkg::HueW-1:0]   hue_next;
    logic [hsvc_pkg::ChanW-1:0]  sat_reg;
    logic [hsvc_pkg::ChanW-1:0]  sat_next;
    logic [hsvc_pkg::ChanW-1:0]  value_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (in_word.zero)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            sat_next = in_word.sat_quo[hsvc_pkg::ChanW-1:0];
            if (in_word.hue_quo >= hsvc_pkg::HueW'(hsvc_pkg::HueFull))
            begin
                hue_next = in_word.hue_quo - hsvc_pkg::HueW'(hsvc_pkg::HueFull);
            end
            else
            begin
                hue_next = in_word.hue_quo;
            end
        end

        if (in_word.value < thresholds.black_value_limit)
        begin
            class_next = hsvc_pkg::CLASS_BLACK;
        end
        else if (hue_next >= thresholds.red_high_hue_min
                 || hue_next <= thresholds.red_low_hue_max)
        begin
            class_next = hsvc_pkg::CLASS_RED;
        end
        else if (hue_next >= thresholds.blue_hue_min
                 && hue_next <= thresholds.blue_hue_max)
        begin
            class_next = hsvc_pkg::CLASS_BLUE;
        end
        else
        begin
            class_next = hsvc_pkg::CLASS_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            class_reg <= class_next;
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= in_word.value;
        end
    end

    assign out_valid        = valid_reg;
    assign colour_class     = class_reg;
    assign hue_degrees      = hue_reg;
    assign saturation_level = sat_reg;
    assign value_level      = value_reg;

endmodule

// ===== rtl/pixel_hsv_colour_classifier.sv =====
// ----------------------------------------------------------------------------
// Pixel HSV colour classifier
// Converts a B,G,R pixel to HSV and classifies it as black, red, blue or none.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  pixel    in         blue_level, green_level, red_level
//  result   out        colour_class, hue_degrees, saturation_level, value_level
//  cfg      in         index, data (threshold register write)
//
// One pixel enters per cycle unless stalled from the output; each passes
// the front cell, nine division cells (one quotient bit each) and output cell.
// Reset clears every cell's valid bit and loads the threshold reset values.
// A stalled result holds only the cells behind it; empty cells keep filling.
// ----------------------------------------------------------------------------
module pixel_hsv_colour_classifier (
    input  logic          clk,
    input  logic          rst_n,
    hsvc_pixel_if.sink    pixel,
    hsvc_result_if.source result,
    hsvc_cfg_if.sink      cfg
);

    hsvc_pkg::thresholds_t thresholds_reg;
    hsvc_pkg::div_word_t   words [hsvc_pkg::QuotW + 1];
    logic                  valids [hsvc_pkg::QuotW + 1];
    logic                  readys [hsvc_pkg::QuotW + 1];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresholds_reg.black_value_limit <= hsvc_pkg::BLACK_VALUE_LIMIT_RST;
            thresholds_reg.red_low_hue_max   <= hsvc_pkg::RED_LOW_HUE_MAX_RST;
            thresholds_reg.red_high_hue_min  <= hsvc_pkg::RED_HIGH_HUE_MIN_RST;
            thresholds_reg.blue_hue_min      <= hsvc_pkg::BLUE_HUE_MIN_RST;
            thresholds_reg.blue_hue_max      <= hsvc_pkg::BLUE_HUE_MAX_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                hsvc_pkg::REG_BLACK_VALUE_LIMIT:
                    thresholds_reg.black_value_limit <= cfg.data[hsvc_pkg::ChanW-1:0];
                hsvc_pkg::REG_RED_LOW_HUE_MAX:
                    thresholds_reg.red_low_hue_max <= cfg.data;
                hsvc_pkg::REG_RED_HIGH_HUE_MIN:
                    thresholds_reg.red_high_hue_min <= cfg.data;
                hsvc_pkg::REG_BLUE_HUE_MIN:
                    thresholds_reg.blue_hue_min <= cfg.data;
                hsvc_pkg::REG_BLUE_HUE_MAX:
                    thresholds_reg.blue_hue_max <= cfg.data;
                default:
                    ;
            endcase
        end
    end

    hsvc_prep_cell u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pixel.valid),
        .in_ready    (pixel.ready),
        .blue_level  (pixel.blue_level),
        .green_level (pixel.green_level),
        .red_level   (pixel.red_level),
        .out_valid   (valids[0]),
        .out_ready   (readys[0]),
        .out_word    (words[0])
    );

    for (genvar g = 0; g < hsvc_pkg::QuotW; g++)
    begin : g_div
        hsvc_div_cell #(
            .BitIndex (hsvc_pkg::QuotW - 1 - g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valids[g]),
            .in_ready  (readys[g]),
            .in_word   (words[g]),
            .out_valid (valids[g + 1]),
            .out_ready (readys[g + 1]),
            .out_word  (words[g + 1])
        );
    end

    hsvc_class_cell u_class (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (valids[hsvc_pkg::QuotW]),
        .in_ready         (readys[hsvc_pkg::QuotW]),
        .in_word          (words[hsvc_pkg::QuotW]),
        .thresholds       (thresholds_reg),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .colour_class     (result.colour_class),
        .hue_degrees      (result.hue_degrees),
        .saturation_level (result.saturation_level),
        .value_level      (result.value_level)
    );

`ifndef SYNTHESIS
    // The input side can only be held off by a result that is not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (result.valid && !result.ready))
        else $error("input stalled without an output stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.hue_degrees < hsvc_pkg::HueW'(hsvc_pkg::HueFull)))
        else $error("hue out of range");

    // Zero saturation only comes from a grey pixel, whose hue is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.saturation_level == '0) |-> (result.hue_degrees == '0))
        else $error("zero saturation with nonzero hue");
`endif

endmodule

// ===== tb/pixel_hsv_colour_classifier_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel HSV colour classifier testbench
// Feeds B,G,R pixels through the classifier under several threshold settings,
// predicts hue, saturation, value and class for every accepted pixel, and
// compares each result with the oldest prediction. Both channels idle at
// random, and one long result stall fills the pipeline.
// ----------------------------------------------------------------------------
module pixel_hsv_colour_classifier_test;

    localparam int CycleLimit    = 200000;
    localparam int HoldOffCycles = 300;
    localparam int DrainCycles   = 40;
    localparam int PhaseItems    = 270;
    localparam int MaxPrinted    = 100;

    typedef struct packed {
        logic [hsvc_pkg::ChanW-1:0] blue;
        logic [hsvc_pkg::ChanW-1:0] green;
        logic [hsvc_pkg::ChanW-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [hsvc_pkg::ClassW-1:0] colour_class;
        logic [hsvc_pkg::HueW-1:0]   hue_degrees;
        logic [hsvc_pkg::ChanW-1:0]  saturation_level;
        logic [hsvc_pkg::ChanW-1:0]  value_level;
    } hsv_result_t;

    typedef struct packed {
        logic [hsvc_pkg::IndexW-1:0] index;
        logic [hsvc_pkg::DataW-1:0]  data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic sink_hold = 1'b0;

    hsvc_pixel_if  pixel_ch ();
    hsvc_result_if result_ch ();
    hsvc_cfg_if    cfg_ch ();

    pixel_hsv_colour_classifier DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    pixel_t                pending_pixels[$];
    reg_write_t            pending_writes[$];
    hsv_result_t           expected_results[$];
    pixel_t                offered_pixel;
    reg_write_t            offered_write;
    hsv_result_t           oldest_expected;
    hsvc_pkg::thresholds_t thresholds;

    int pixels_outstanding = 0;
    int writes_outstanding = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic hsv_result_t classify_pixel(input pixel_t px,
                                                   input hsvc_pkg::thresholds_t th);
        int b, g, r, mx, mn, d, num, hue, sat;
        hsv_result_t res;
        b = int'(px.blue);
        g = int'(px.green);
        r = int'(px.red);
        mx = b;
        mn = b;
        if (g > mx) mx = g;
        if (r > mx) mx = r;
        if (g < mn) mn = g;
        if (r < mn) mn = r;
        d = mx - mn;
        hue = 0;
        sat = 0;
        if (mx != 0 && d != 0)
        begin
            sat = (hsvc_pkg::SatScale2 * d + mx) / (2 * mx);
            if (mx == b)
                num = hsvc_pkg::HueBlueBase * d + hsvc_pkg::HueSector * (r - g);
            else if (mx == g)
                num = hsvc_pkg::HueGreenBase * d + hsvc_pkg::HueSector * (b - r);
            else
                num = hsvc_pkg::HueSector * (g - b);
            if (num < 0)
                num += hsvc_pkg::HueFull * d;
            hue = (2 * num + d) / (2 * d);
            if (hue >= hsvc_pkg::HueFull)
                hue -= hsvc_pkg::HueFull;
        end
        if (mx < int'(th.black_value_limit))
            res.colour_class = hsvc_pkg::CLASS_BLACK;
        else if (hue >= int'(th.red_high_hue_min) || hue <= int'(th.red_low_hue_max))
            res.colour_class = hsvc_pkg::CLASS_RED;
        else if (hue >= int'(th.blue_hue_min) && hue <= int'(th.blue_hue_max))
            res.colour_class = hsvc_pkg::CLASS_BLUE;
        else
            res.colour_class = hsvc_pkg::CLASS_NONE;
        res.hue_degrees = hsvc_pkg::HueW'(hue);
        res.saturation_level = hsvc_pkg::ChanW'(sat);
        res.value_level = hsvc_pkg::ChanW'(mx);
        return res;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        logic [hsvc_pkg::ChanW-1:0] level;
        int mode;
        mode = int'($urandom_range(9));
        level = hsvc_pkg::ChanW'($urandom_range(255));
        px.blue = hsvc_pkg::ChanW'($urandom_range(255));
        px.green = hsvc_pkg::ChanW'($urandom_range(255));
        px.red = hsvc_pkg::ChanW'($urandom_range(255));
        case (mode)
            0:
            begin
                px.blue = level;
                px.green = level;
                px.red = level;
            end
            1: px.green = px.blue;
            2: px.red = px.green;
            3: px.red = px.blue;
            4:
            begin
                px.blue = hsvc_pkg::ChanW'($urandom_range(3));
                px.green = hsvc_pkg::ChanW'($urandom_range(3));
                px.red = hsvc_pkg::ChanW'($urandom_range(3));
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MaxPrinted)
            $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_pixel(input pixel_t px);
        pending_pixels.push_back(px);
        pixels_outstanding++;
    endtask

    task automatic queue_write(input logic [hsvc_pkg::IndexW-1:0] index,
                               input logic [hsvc_pkg::DataW-1:0] data);
        pending_writes.push_back('{index, data});
        writes_outstanding++;
    endtask

    task automatic wait_for_drain();
        while (pixels_outstanding != 0 || writes_outstanding != 0 ||
               expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [hsvc_pkg::DataW-1:0] black,
                                  input logic [hsvc_pkg::DataW-1:0] red_low,
                                  input logic [hsvc_pkg::DataW-1:0] red_high,
                                  input logic [hsvc_pkg::DataW-1:0] blue_min,
                                  input logic [hsvc_pkg::DataW-1:0] blue_max);
        queue_write(hsvc_pkg::REG_BLACK_VALUE_LIMIT, black);
        queue_write(hsvc_pkg::REG_RED_LOW_HUE_MAX, red_low);
        queue_write(hsvc_pkg::REG_RED_HIGH_HUE_MIN, red_high);
        queue_write(hsvc_pkg::REG_BLUE_HUE_MIN, blue_min);
        queue_write(hsvc_pkg::REG_BLUE_HUE_MAX, blue_max);
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct);
        wait_for_drain();
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (PhaseItems) queue_pixel(random_pixel());
        wait_for_drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_ch.valid <= 1'b0;
            pixel_ch.blue_level <= '0;
            pixel_ch.green_level <= '0;
            pixel_ch.red_level <= '0;
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data <= '0;
            thresholds = '{hsvc_pkg::BLACK_VALUE_LIMIT_RST, hsvc_pkg::RED_LOW_HUE_MAX_RST,
                           hsvc_pkg::RED_HIGH_HUE_MIN_RST, hsvc_pkg::BLUE_HUE_MIN_RST,
                           hsvc_pkg::BLUE_HUE_MAX_RST};
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                expected_results.push_back(classify_pixel(offered_pixel, thresholds));
                pixels_outstanding--;
            end
            if (!pixel_ch.valid || pixel_ch.ready)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_pixel = pending_pixels.pop_front();
                    pixel_ch.valid <= 1'b1;
                    pixel_ch.blue_level <= offered_pixel.blue;
                    pixel_ch.green_level <= offered_pixel.green;
                    pixel_ch.red_level <= offered_pixel.red;
                end
                else
                    pixel_ch.valid <= 1'b0;
            end

            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (offered_write.index)
                    hsvc_pkg::REG_BLACK_VALUE_LIMIT:
                        thresholds.black_value_limit =
                            offered_write.data[hsvc_pkg::ChanW-1:0];
                    hsvc_pkg::REG_RED_LOW_HUE_MAX:
                        thresholds.red_low_hue_max = offered_write.data;
                    hsvc_pkg::REG_RED_HIGH_HUE_MIN:
                        thresholds.red_high_hue_min = offered_write.data;
                    hsvc_pkg::REG_BLUE_HUE_MIN:
                        thresholds.blue_hue_min = offered_write.data;
                    hsvc_pkg::REG_BLUE_HUE_MAX:
                        thresholds.blue_hue_max = offered_write.data;
                    default: ;
                endcase
                writes_outstanding--;
            end
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (pending_writes.size() != 0)
                begin
                    offered_write = pending_writes.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= offered_write.index;
                    cfg_ch.data <= offered_write.data;
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no pending pixel, class", result_ch.colour_class, 0);
                else
                begin
                    oldest_expected = expected_results.pop_front();
                    if (result_ch.colour_class !== oldest_expected.colour_class)
                        report_mismatch("colour_class", result_ch.colour_class,
                                        oldest_expected.colour_class);
                    if (result_ch.hue_degrees !== oldest_expected.hue_degrees)
                        report_mismatch("hue_degrees", result_ch.hue_degrees,
                                        oldest_expected.hue_degrees);
                    if (result_ch.saturation_level !== oldest_expected.saturation_level)
                        report_mismatch("saturation_level", result_ch.saturation_level,
                                        oldest_expected.saturation_level);
                    if (result_ch.value_level !== oldest_expected.value_level)
                        report_mismatch("value_level", result_ch.value_level,
                                        oldest_expected.value_level);
                end
            end
            result_ch.ready <= !sink_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_pixel('{8'd0, 8'd0, 8'd0});
        queue_pixel('{8'd255, 8'd255, 8'd255});
        queue_pixel('{8'd128, 8'd128, 8'd128});
        queue_pixel('{8'd255, 8'd0, 8'd0});
        queue_pixel('{8'd0, 8'd255, 8'd0});
        queue_pixel('{8'd0, 8'd0, 8'd255});
        queue_pixel('{8'd255, 8'd255, 8'd0});
        queue_pixel('{8'd0, 8'd255, 8'd255});
        queue_pixel('{8'd255, 8'd0, 8'd255});
        queue_pixel('{8'd1, 8'd0, 8'd255});
        queue_pixel('{8'd2, 8'd0, 8'd255});
        queue_pixel('{8'd3, 8'd0, 8'd255});
        queue_pixel('{8'd0, 8'd49, 8'd49});
        queue_pixel('{8'd0, 8'd50, 8'd50});
        queue_pixel('{8'd1, 8'd0, 8'd0});
        queue_pixel('{8'd254, 8'd255, 8'd0});
        queue_pixel('{8'd200, 8'd100, 8'd50});
        queue_pixel('{8'd0, 8'd128, 8'd255});
        queue_pixel('{8'd0, 8'd60, 8'd240});
        queue_pixel('{8'd0, 8'd64, 8'd240});
        queue_pixel('{8'd80, 8'd0, 8'd240});
        queue_pixel('{8'd240, 8'd160, 8'd0});
        queue_pixel('{8'd240, 8'd0, 8'd80});
        queue_pixel('{8'd240, 8'd0, 8'd84});
        wait_for_drain();

        set_thresholds(9'd0, 9'd0, 9'd360, 9'd180, 9'd300);
        queue_write(3'd5, 9'd0);
        run_random_phase(0, 0);

        set_thresholds(9'h1FF, 9'd511, 9'd0, 9'd0, 9'd511);
        run_random_phase(56, 0);

        set_thresholds(9'd128, 9'd30, 9'd330, 9'd90, 9'd150);
        queue_write(3'd6, 9'd511);
        queue_write(3'd7, 9'h0AA);
        run_random_phase(0, 56);

        set_thresholds(9'd20, 9'd0, 9'd511, 9'd300, 9'd100);
        run_random_phase(37, 37);

        set_thresholds(9'd50, 9'd15, 9'd340, 9'd200, 9'd260);
        wait_for_drain();
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HoldOffCycles) @(posedge clk);
                sink_hold <= 1'b0;
            end
        join_none
        run_random_phase(0, 0);

        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== pixel_hsv_colour_classifier.f =====
rtl/hsvc_pkg.sv
rtl/hsvc_if.sv
rtl/hsvc_prep_cell.sv
rtl/hsvc_div_cell.sv
rtl/hsvc_class_cell.sv
rtl/pixel_hsv_colour_classifier.sv
tb/pixel_hsv_colour_classifier_test.sv
